// ===== src/gors_pkg.sv =====
// Shared types, constants and direction helpers for the grid obstacle ray scanner.
package gors_pkg;

    localparam int GRID_ROWS_DEF = 32;
    localparam int GRID_COLS_DEF = 32;

    localparam int COORD_W   = 5;
    localparam int CODE_W    = 3;
    localparam int DIST_W    = 5;
    localparam int CFG_W     = 6;
    localparam int CFG_IDX_W = 1;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [DIST_W-1:0] DIST_MAX = 5'd31;

    localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_IN_USE = 1'd1;

    localparam logic [CFG_W-1:0] ROWS_RESET = 6'd18;
    localparam logic [CFG_W-1:0] COLS_RESET = 6'd20;

    localparam logic [CODE_W-1:0] CODE_FREE = 3'd0;
    localparam logic [CODE_W-1:0] CODE_DOCK = 3'd4;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_SCAN  = 1'b1;

    typedef struct packed {
        logic               action;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [CODE_W-1:0]  cell_code;
    } in_item_t;

    typedef struct packed {
        logic [DIST_W-1:0] dist_up;
        logic [DIST_W-1:0] dist_up_right;
        logic [DIST_W-1:0] dist_right;
        logic [DIST_W-1:0] dist_down_right;
        logic [DIST_W-1:0] dist_down;
        logic [DIST_W-1:0] dist_down_left;
        logic [DIST_W-1:0] dist_left;
        logic [DIST_W-1:0] dist_up_left;
        logic              position_invalid;
    } result_t;

    typedef enum logic [2:0] {
        DIR_UP,
        DIR_UP_RIGHT,
        DIR_RIGHT,
        DIR_DOWN_RIGHT,
        DIR_DOWN,
        DIR_DOWN_LEFT,
        DIR_LEFT,
        DIR_UP_LEFT
    } dir_t;

    typedef enum logic [1:0] {
        MV_HOLD,
        MV_INC,
        MV_DEC
    } move_t;

    typedef enum logic [1:0] {
        CMD_WRITE,
        CMD_SCAN,
        CMD_SCAN_BAD
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               blocked;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } q_head_t;

    typedef struct packed {
        logic clearing;
    } back_status_t;

    function automatic move_t row_move(input dir_t dir);
        move_t mv;
        case (dir)
            DIR_UP, DIR_UP_RIGHT, DIR_UP_LEFT:        mv = MV_DEC;
            DIR_DOWN_RIGHT, DIR_DOWN, DIR_DOWN_LEFT:  mv = MV_INC;
            default:                                  mv = MV_HOLD;
        endcase
        return mv;
    endfunction

    function automatic move_t col_move(input dir_t dir);
        move_t mv;
        case (dir)
            DIR_UP_RIGHT, DIR_RIGHT, DIR_DOWN_RIGHT:  mv = MV_INC;
            DIR_DOWN_LEFT, DIR_LEFT, DIR_UP_LEFT:     mv = MV_DEC;
            default:                                  mv = MV_HOLD;
        endcase
        return mv;
    endfunction

endpackage

// ===== src/gors_ram.sv =====
// Generic single-port RAM with registered read data.
module gors_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== src/gors_front.sv =====
// Front end: accepts items, classifies them against the grid in use and queues them.
module gors_front #(
    parameter int GRID_ROWS = gors_pkg::GRID_ROWS_DEF,
    parameter int GRID_COLS = gors_pkg::GRID_COLS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  gors_pkg::in_item_t               item,
    input  logic [$clog2(GRID_ROWS+1)-1:0]   rows_act,
    input  logic [$clog2(GRID_COLS+1)-1:0]   cols_act,
    input  gors_pkg::back_status_t           status,
    input  logic                             pop,
    output gors_pkg::q_head_t                head
);
    import gors_pkg::*;

    localparam int NRW   = $clog2(GRID_ROWS + 1);
    localparam int NCW   = $clog2(GRID_COLS + 1);
    localparam int RCMPW = (NRW > COORD_W) ? NRW : COORD_W;
    localparam int CCMPW = (NCW > COORD_W) ? NCW : COORD_W;
    localparam int QPW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW   = $clog2(QUEUE_DEPTH + 1);

    cmd_t           q_mem_reg [QUEUE_DEPTH];
    logic [QPW-1:0] wr_ptr_reg;
    logic [QPW-1:0] rd_ptr_reg;
    logic [QCW-1:0] count_reg;

    logic in_grid;
    logic accept;
    logic push;
    cmd_t cmd_new;

    always_comb
    begin
        in_grid = (RCMPW'(item.row) < RCMPW'(rows_act)) &&
                  (CCMPW'(item.col) < CCMPW'(cols_act));
        busy    = (count_reg == QCW'(QUEUE_DEPTH)) || status.clearing;
        accept  = start && !busy;

        cmd_new.row     = item.row;
        cmd_new.col     = item.col;
        cmd_new.blocked = (item.cell_code != CODE_FREE) && (item.cell_code != CODE_DOCK);
        if (item.action == ACT_WRITE)
        begin
            cmd_new.kind = CMD_WRITE;
        end
        else if (in_grid)
        begin
            cmd_new.kind = CMD_SCAN;
        end
        else
        begin
            cmd_new.kind = CMD_SCAN_BAD;
        end

        // Writes outside the grid in use are dropped here and never reach the back end.
        push = accept && ((item.action == ACT_SCAN) || in_grid);

        head.valid = (count_reg != '0);
        head.cmd   = q_mem_reg[rd_ptr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= cmd_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPW'(QUEUE_DEPTH - 1)) ? '0 :
                              QPW'(wr_ptr_reg + QPW'(1));
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPW'(QUEUE_DEPTH - 1)) ? '0 :
                              QPW'(rd_ptr_reg + QPW'(1));
            end
            if (push && !pop)
            begin
                count_reg <= QCW'(count_reg + QCW'(1));
            end
            else if (pop && !push)
            begin
                count_reg <= QCW'(count_reg - QCW'(1));
            end
        end
    end

endmodule

// ===== src/gors_back.sv =====
// Back end: owns the grid memory, clears it after reset, performs writes and walks the rays.
module gors_back #(
    parameter int GRID_ROWS = gors_pkg::GRID_ROWS_DEF,
    parameter int GRID_COLS = gors_pkg::GRID_COLS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [$clog2(GRID_ROWS+1)-1:0]   rows_act,
    input  logic [$clog2(GRID_COLS+1)-1:0]   cols_act,
    input  gors_pkg::q_head_t                head,
    output logic                             pop,
    output gors_pkg::back_status_t           status,
    output logic                             result_valid,
    output gors_pkg::result_t                result
);
    import gors_pkg::*;

    localparam int DEPTH = GRID_ROWS * GRID_COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int RW    = $clog2(GRID_ROWS);
    localparam int CW    = $clog2(GRID_COLS);
    localparam int NRW   = $clog2(GRID_ROWS + 1);
    localparam int NCW   = $clog2(GRID_COLS + 1);
    localparam int MAXG  = (GRID_ROWS > GRID_COLS) ? GRID_ROWS : GRID_COLS;
    localparam int SW    = $clog2(MAXG + 1);
    localparam int SCW   = (SW > DIST_W) ? SW : DIST_W;
    localparam int NDIR  = 8;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_REPORT
    } state_t;

    state_t            state_reg;
    logic [AW-1:0]     clr_addr_reg;
    dir_t              dir_reg;
    logic [RW-1:0]     orig_r_reg;
    logic [CW-1:0]     orig_c_reg;
    logic [RW-1:0]     r_reg;
    logic [CW-1:0]     c_reg;
    logic [SW-1:0]     steps_reg;
    logic              pend_reg;
    logic [DIST_W-1:0] dist_reg [NDIR];
    logic              result_valid_reg;
    result_t           result_reg;

    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [0:0]    ram_wdata;
    logic [0:0]    ram_rdata;

    move_t             row_mv;
    move_t             col_mv;
    logic              at_edge;
    logic              hit;
    logic [RW-1:0]     step_r;
    logic [CW-1:0]     step_c;
    logic [RW-1:0]     head_r;
    logic [CW-1:0]     head_c;
    logic [AW-1:0]     walk_addr;
    logic [AW-1:0]     head_addr;
    logic [DIST_W-1:0] sat_steps;
    result_t           bad_result;

    gors_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_grid_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        row_mv = row_move(dir_reg);
        col_mv = col_move(dir_reg);

        // The ray ends when the next cell would leave the grid in use.
        at_edge = ((row_mv == MV_DEC) && (r_reg == '0)) ||
                  ((row_mv == MV_INC) && ((NRW'(r_reg) + NRW'(1)) == rows_act)) ||
                  ((col_mv == MV_DEC) && (c_reg == '0)) ||
                  ((col_mv == MV_INC) && ((NCW'(c_reg) + NCW'(1)) == cols_act));

        // The read issued last cycle returns now; a set bit ends the ray.
        hit = pend_reg && ram_rdata[0];

        case (row_mv)
            MV_INC:  step_r = RW'(r_reg + RW'(1));
            MV_DEC:  step_r = RW'(r_reg - RW'(1));
            default: step_r = r_reg;
        endcase
        case (col_mv)
            MV_INC:  step_c = CW'(c_reg + CW'(1));
            MV_DEC:  step_c = CW'(c_reg - CW'(1));
            default: step_c = c_reg;
        endcase

        head_r    = RW'(head.cmd.row);
        head_c    = CW'(head.cmd.col);
        walk_addr = AW'(AW'(step_r) * AW'(GRID_COLS) + AW'(step_c));
        head_addr = AW'(AW'(head_r) * AW'(GRID_COLS) + AW'(head_c));

        sat_steps = (SCW'(steps_reg) > SCW'(DIST_MAX)) ? DIST_MAX : DIST_W'(steps_reg);

        bad_result                  = '0;
        bad_result.position_invalid = 1'b1;

        ram_we    = 1'b0;
        ram_addr  = walk_addr;
        ram_wdata = 1'b0;
        pop       = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we   = 1'b1;
                ram_addr = clr_addr_reg;
            end
            ST_IDLE:
            begin
                pop = head.valid;
                if (head.valid && (head.cmd.kind == CMD_WRITE))
                begin
                    ram_we    = 1'b1;
                    ram_addr  = head_addr;
                    ram_wdata = head.cmd.blocked;
                end
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase

        status.clearing = (state_reg == ST_CLEAR);
        result_valid    = result_valid_reg;
        result          = result_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            clr_addr_reg     <= '0;
            dir_reg          <= DIR_UP;
            pend_reg         <= 1'b0;
            steps_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= 1'b0;
            case (state_reg)
                ST_CLEAR:
                begin
                    clr_addr_reg <= AW'(clr_addr_reg + AW'(1));
                    if (clr_addr_reg == AW'(DEPTH - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (head.valid)
                    begin
                        case (head.cmd.kind)
                            CMD_SCAN:
                            begin
                                orig_r_reg <= head_r;
                                orig_c_reg <= head_c;
                                r_reg      <= head_r;
                                c_reg      <= head_c;
                                dir_reg    <= DIR_UP;
                                steps_reg  <= '0;
                                pend_reg   <= 1'b0;
                                state_reg  <= ST_WALK;
                            end
                            CMD_SCAN_BAD:
                            begin
                                result_reg       <= bad_result;
                                result_valid_reg <= 1'b1;
                            end
                            default:
                            begin
                                pend_reg <= 1'b0;
                            end
                        endcase
                    end
                end
                ST_WALK:
                begin
                    if (hit || at_edge)
                    begin
                        dist_reg[dir_reg] <= hit ? sat_steps : '0;
                        r_reg             <= orig_r_reg;
                        c_reg             <= orig_c_reg;
                        steps_reg         <= '0;
                        pend_reg          <= 1'b0;
                        if (dir_reg == DIR_UP_LEFT)
                        begin
                            state_reg <= ST_REPORT;
                        end
                        else
                        begin
                            dir_reg <= dir_t'(dir_reg + 3'd1);
                        end
                    end
                    else
                    begin
                        r_reg     <= step_r;
                        c_reg     <= step_c;
                        steps_reg <= SW'(steps_reg + SW'(1));
                        pend_reg  <= 1'b1;
                    end
                end
                ST_REPORT:
                begin
                    result_reg.dist_up          <= dist_reg[DIR_UP];
                    result_reg.dist_up_right    <= dist_reg[DIR_UP_RIGHT];
                    result_reg.dist_right       <= dist_reg[DIR_RIGHT];
                    result_reg.dist_down_right  <= dist_reg[DIR_DOWN_RIGHT];
                    result_reg.dist_down        <= dist_reg[DIR_DOWN];
                    result_reg.dist_down_left   <= dist_reg[DIR_DOWN_LEFT];
                    result_reg.dist_left        <= dist_reg[DIR_LEFT];
                    result_reg.dist_up_left     <= dist_reg[DIR_UP_LEFT];
                    result_reg.position_invalid <= 1'b0;
                    result_valid_reg            <= 1'b1;
                    state_reg                   <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== src/grid_obstacle_ray_scan.sv =====
// Top level of the grid obstacle ray scanner: configuration registers, front end and back end.
//
// After reset the block clears its GRID_ROWS*GRID_COLS-bit grid memory, one cell
// per cycle, and holds busy high meanwhile; configuration writes are taken
// during that time. An item is accepted when start is high and busy is low,
// and a two-entry queue lets two items wait while the back end works, so after
// the clearing pass busy rises only when that queue is full. A write item is
// performed by the back end from its idle state and gives no result; a write
// outside the grid in use is dropped at the input. A scan outside the grid in
// use gives its result from the result register once the back end takes it
// from the queue. A valid scan walks the eight rays with one grid memory read
// per cycle: each step checks the cell read last cycle while it reads the next
// one, and the scan starts, walks, reports and then shows the result. The
// length of the rays therefore sets the time a scan takes; at most 123 cells
// are examined around one position on a 32 by 32 grid. Each result is shown
// for exactly one cycle with result_valid high and must be taken then, since
// the receiver cannot stall the block.
module grid_obstacle_ray_scan #(
    parameter int GRID_ROWS = gors_pkg::GRID_ROWS_DEF,
    parameter int GRID_COLS = gors_pkg::GRID_COLS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  gors_pkg::in_item_t                   item,
    input  logic                                 cfg_we,
    input  logic [gors_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [gors_pkg::CFG_W-1:0]           cfg_data,
    output logic                                 result_valid,
    output gors_pkg::result_t                    result
);
    import gors_pkg::*;

    localparam int NRW   = $clog2(GRID_ROWS + 1);
    localparam int NCW   = $clog2(GRID_COLS + 1);
    localparam int RCMPW = (NRW > CFG_W) ? NRW : CFG_W;
    localparam int CCMPW = (NCW > CFG_W) ? NCW : CFG_W;

    logic [CFG_W-1:0] rows_in_use_reg;
    logic [CFG_W-1:0] cols_in_use_reg;
    logic [NRW-1:0]   rows_act;
    logic [NCW-1:0]   cols_act;

    q_head_t      head;
    logic         pop;
    back_status_t status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_in_use_reg <= ROWS_RESET;
            cols_in_use_reg <= COLS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ROWS_IN_USE: rows_in_use_reg <= cfg_data;
                REG_COLS_IN_USE: cols_in_use_reg <= cfg_data;
                default:         rows_in_use_reg <= rows_in_use_reg;
            endcase
        end
    end

    // Register values above the built grid size are clamped to it.
    always_comb
    begin
        rows_act = (RCMPW'(rows_in_use_reg) > RCMPW'(GRID_ROWS)) ? NRW'(GRID_ROWS) :
                   NRW'(rows_in_use_reg);
        cols_act = (CCMPW'(cols_in_use_reg) > CCMPW'(GRID_COLS)) ? NCW'(GRID_COLS) :
                   NCW'(cols_in_use_reg);
    end

    gors_front #(
        .GRID_ROWS (GRID_ROWS),
        .GRID_COLS (GRID_COLS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .item     (item),
        .rows_act (rows_act),
        .cols_act (cols_act),
        .status   (status),
        .pop      (pop),
        .head     (head)
    );

    gors_back #(
        .GRID_ROWS (GRID_ROWS),
        .GRID_COLS (GRID_COLS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .rows_act     (rows_act),
        .cols_act     (cols_act),
        .head         (head),
        .pop          (pop),
        .status       (status),
        .result_valid (result_valid),
        .result       (result)
    );

    a_clear_holds_busy: assert property (@(posedge clk) disable iff (!rst_n)
        status.clearing |-> busy)
        else $error("item could be accepted during the grid clearing pass");

    a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        status.clearing |-> !result_valid)
        else $error("result strobe during the grid clearing pass");

    a_invalid_all_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.position_invalid) |->
        (result.dist_up == '0 && result.dist_up_right == '0 &&
         result.dist_right == '0 && result.dist_down_right == '0 &&
         result.dist_down == '0 && result.dist_down_left == '0 &&
         result.dist_left == '0 && result.dist_up_left == '0))
        else $error("invalid scan position reported a nonzero distance");

    a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head.valid)
        else $error("back end took an item from an empty queue");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for grid_obstacle_ray_scan: directed table, then random phases.
module tb_top;
    import gors_pkg::*;

    localparam int SETTLE_CYCLES = 16;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int PHASE_ITEMS   = 150;
    localparam int NUM_PHASES    = 10;
    localparam int FIXED_PHASES  = 7;

    typedef struct {
        in_item_t it;
        bit       typed;
        result_t  want;
    } stim_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    in_item_t             item = '0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 result_valid;
    result_t              result;

    // Shadow of the block's state and configuration.
    bit               blocked_cells [GRID_ROWS_DEF][GRID_COLS_DEF];
    logic [CFG_W-1:0] rows_reg = ROWS_RESET;
    logic [CFG_W-1:0] cols_reg = COLS_RESET;
    result_t          pending_scans [$];
    int               failures = 0;

    grid_obstacle_ray_scan dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result       (result)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic int rows_active();
        return (rows_reg > GRID_ROWS_DEF) ? GRID_ROWS_DEF : int'(rows_reg);
    endfunction

    function automatic int cols_active();
        return (cols_reg > GRID_COLS_DEF) ? GRID_COLS_DEF : int'(cols_reg);
    endfunction

    // Steps to the first blocked cell along one ray; 0 when the edge comes first.
    function automatic logic [DIST_W-1:0] ray_steps(int r0, int c0, int dr, int dc);
        int r;
        int c;
        int steps;
        int nr;
        int nc;
        nr = rows_active();
        nc = cols_active();
        r = r0 + dr;
        c = c0 + dc;
        steps = 1;
        while (r >= 0 && r < nr && c >= 0 && c < nc)
        begin
            if (blocked_cells[r][c])
                return (steps > DIST_MAX) ? DIST_MAX : DIST_W'(steps);
            r += dr;
            c += dc;
            steps++;
        end
        return '0;
    endfunction

    function automatic result_t scan_from(logic [COORD_W-1:0] row, logic [COORD_W-1:0] col);
        result_t res;
        res = '0;
        if (row >= rows_active() || col >= cols_active())
        begin
            res.position_invalid = 1'b1;
            return res;
        end
        res.dist_up         = ray_steps(row, col, -1,  0);
        res.dist_up_right   = ray_steps(row, col, -1,  1);
        res.dist_right      = ray_steps(row, col,  0,  1);
        res.dist_down_right = ray_steps(row, col,  1,  1);
        res.dist_down       = ray_steps(row, col,  1,  0);
        res.dist_down_left  = ray_steps(row, col,  1, -1);
        res.dist_left       = ray_steps(row, col,  0, -1);
        res.dist_up_left    = ray_steps(row, col, -1, -1);
        return res;
    endfunction

    // Applies an accepted item to the shadow grid or queues the scan result it causes.
    function automatic void record_item(in_item_t it, bit typed, result_t want);
        if (it.action == ACT_SCAN)
            pending_scans.push_back(typed ? want : scan_from(it.row, it.col));
        else if (it.row < rows_active() && it.col < cols_active())
            blocked_cells[it.row][it.col] =
                !(it.cell_code == CODE_FREE || it.cell_code == CODE_DOCK);
    endfunction

    function automatic stim_row_t stim_row(logic act, int r, int c, int code, bit typed,
                                           result_t want);
        stim_row_t s;
        s.it.action    = act;
        s.it.row       = COORD_W'(r);
        s.it.col       = COORD_W'(c);
        s.it.cell_code = CODE_W'(code);
        s.typed        = typed;
        s.want         = want;
        return s;
    endfunction

    function automatic in_item_t random_item(int block_pct);
        in_item_t it;
        int nr;
        int nc;
        nr = rows_active();
        nc = cols_active();
        it.action = ($urandom_range(0, 99) < 40) ? ACT_SCAN : ACT_WRITE;
        // Most positions fall inside the grid in use so that scans walk real rays.
        if (nr > 0 && nc > 0 && $urandom_range(0, 99) < 85)
        begin
            it.row = COORD_W'($urandom_range(0, nr - 1));
            it.col = COORD_W'($urandom_range(0, nc - 1));
        end
        else
        begin
            it.row = COORD_W'($urandom);
            it.col = COORD_W'($urandom);
        end
        if ($urandom_range(0, 99) < block_pct)
        begin
            do
                it.cell_code = CODE_W'($urandom);
            while (it.cell_code == CODE_FREE || it.cell_code == CODE_DOCK);
        end
        else
        begin
            it.cell_code = $urandom_range(0, 1) ? CODE_DOCK : CODE_FREE;
        end
        return it;
    endfunction

    task automatic send_item(in_item_t it, bit typed, result_t want);
        start <= 1'b1;
        item  <= it;
        do
            @(posedge clk);
        while (busy);
        record_item(it, typed, want);
    endtask

    task automatic idle_gap(bit quiet);
        int pick;
        int len;
        if (quiet)
            return;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            len = 0;
        else if (pick < 92)
            len = $urandom_range(1, 3);
        else
            len = $urandom_range(8, 60);
        if (len > 0)
        begin
            start <= 1'b0;
            repeat (len) @(posedge clk);
        end
    endtask

    // Waits until every scan has reported, then lets queued writes settle.
    task automatic drain();
        int waited;
        start <= 1'b0;
        waited = 0;
        while (pending_scans.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_config(logic [CFG_W-1:0] rows, logic [CFG_W-1:0] cols);
        cfg_we    <= 1'b1;
        cfg_index <= REG_ROWS_IN_USE;
        cfg_data  <= rows;
        @(posedge clk);
        cfg_index <= REG_COLS_IN_USE;
        cfg_data  <= cols;
        @(posedge clk);
        cfg_we   <= 1'b0;
        rows_reg = rows;
        cols_reg = cols;
    endtask

    task automatic check_field(string name, int want, int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid)
        begin
            if (pending_scans.size() == 0)
            begin
                $error("result arrived with no scan outstanding");
                failures++;
            end
            else
            begin
                want = pending_scans.pop_front();
                check_field("dist_up", want.dist_up, result.dist_up);
                check_field("dist_up_right", want.dist_up_right, result.dist_up_right);
                check_field("dist_right", want.dist_right, result.dist_right);
                check_field("dist_down_right", want.dist_down_right, result.dist_down_right);
                check_field("dist_down", want.dist_down, result.dist_down);
                check_field("dist_down_left", want.dist_down_left, result.dist_down_left);
                check_field("dist_left", want.dist_left, result.dist_left);
                check_field("dist_up_left", want.dist_up_left, result.dist_up_left);
                check_field("position_invalid", want.position_invalid,
                            result.position_invalid);
            end
        end
    end

    initial
    begin
        stim_row_t directed [$];
        result_t   clear;
        result_t   off_grid;
        result_t   unused;
        int        phase_rows [FIXED_PHASES];
        int        phase_cols [FIXED_PHASES];
        int        phase_density [FIXED_PHASES];
        int        density;
        bit        quiet;

        clear = '0;
        unused = '0;
        off_grid = '0;
        off_grid.position_invalid = 1'b1;

        // Full grid, single cell, zero rows, both registers above the grid size,
        // single column, single row and zero columns.
        phase_rows    = '{32, 1, 0, 63, 32, 1, 5};
        phase_cols    = '{32, 1, 7, 63, 1, 32, 0};
        phase_density = '{8, 50, 50, 30, 40, 15, 50};

        // Directed items run at the reset size of 18 rows by 20 columns.
        directed.push_back(stim_row(ACT_SCAN, 0, 0, 0, 1'b1, clear));
        directed.push_back(stim_row(ACT_SCAN, 17, 19, 7, 1'b1, clear));
        directed.push_back(stim_row(ACT_SCAN, 18, 0, 0, 1'b1, off_grid));
        directed.push_back(stim_row(ACT_SCAN, 0, 20, 0, 1'b1, off_grid));
        directed.push_back(stim_row(ACT_SCAN, 31, 31, 0, 1'b1, off_grid));
        directed.push_back(stim_row(ACT_WRITE, 31, 31, 7, 1'b0, unused));
        directed.push_back(stim_row(ACT_WRITE, 3, 25, 7, 1'b0, unused));
        directed.push_back(stim_row(ACT_WRITE, 17, 19, 1, 1'b0, unused));
        directed.push_back(stim_row(ACT_WRITE, 0, 0, 7, 1'b0, unused));
        directed.push_back(stim_row(ACT_WRITE, 0, 10, 2, 1'b0, unused));
        directed.push_back(stim_row(ACT_WRITE, 9, 0, 3, 1'b0, unused));
        directed.push_back(stim_row(ACT_WRITE, 9, 10, 5, 1'b0, unused));
        directed.push_back(stim_row(ACT_WRITE, 9, 19, 6, 1'b0, unused));
        directed.push_back(stim_row(ACT_WRITE, 17, 10, 4, 1'b0, unused));
        directed.push_back(stim_row(ACT_WRITE, 4, 14, 1, 1'b0, unused));
        directed.push_back(stim_row(ACT_SCAN, 9, 9, 0, 1'b0, unused));
        directed.push_back(stim_row(ACT_SCAN, 0, 19, 0, 1'b0, unused));
        directed.push_back(stim_row(ACT_WRITE, 9, 10, 0, 1'b0, unused));
        directed.push_back(stim_row(ACT_WRITE, 9, 19, 4, 1'b0, unused));
        directed.push_back(stim_row(ACT_SCAN, 9, 9, 0, 1'b0, unused));
        directed.push_back(stim_row(ACT_SCAN, 17, 0, 0, 1'b0, unused));
        // The vehicle's own cell is blocked here and must not count.
        directed.push_back(stim_row(ACT_SCAN, 0, 0, 0, 1'b0, unused));
        directed.push_back(stim_row(ACT_SCAN, 18, 19, 0, 1'b1, off_grid));
        directed.push_back(stim_row(ACT_SCAN, 17, 20, 0, 1'b1, off_grid));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // The block clears its grid after reset; busy holds the first item off.
        foreach (directed[i])
        begin
            send_item(directed[i].it, directed[i].typed, directed[i].want);
            idle_gap(1'b0);
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain();
            if (p < FIXED_PHASES)
            begin
                write_config(CFG_W'(phase_rows[p]), CFG_W'(phase_cols[p]));
                density = phase_density[p];
            end
            else
            begin
                write_config(CFG_W'($urandom_range(1, 32)), CFG_W'($urandom_range(1, 32)));
                density = $urandom_range(5, 80);
            end
            quiet = (p % 3 == 0);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n == PHASE_ITEMS / 2 && p % 2 == 0)
                    drain();
                send_item(random_item(density), 1'b0, unused);
                idle_gap(quiet);
            end
        end

        drain();
        if (pending_scans.size() != 0)
        begin
            $error("%0d scan results never arrived", pending_scans.size());
            failures++;
        end
        if (failures == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/gors_pkg.sv
src/gors_ram.sv
src/gors_front.sv
src/gors_back.sv
src/grid_obstacle_ray_scan.sv
tb/tb_top.sv
